// ----- rtl/ffra_pkg.sv -----
`timescale 1ns / 1ps
package ffra_pkg;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_CHECK   = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_SPACE  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_OUTSIDE   = 3'd4;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd5;

    localparam logic CFG_BASE_PAGE  = 1'b0;
    localparam logic CFG_POOL_PAGES = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ACHK = 6'b000010,
        S_SCAN = 6'b000100,
        S_SHRD = 6'b001000,
        S_SHWR = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

endpackage

// ----- rtl/first_fit_region_allocator_core.sv -----
`timescale 1ns / 1ps
// First-fit page region allocator. One transfer is worked at a time; the region table sits in a
// single-port-read memory scanned one entry per cycle. A release that finds no region scans every
// occupied entry before its result goes to the output register; a check stops at the first entry
// that holds its page. A release that finds its region shifts each entry behind the removed one
// down by one place. Allocate repeats its scan pass while the candidate start moved during the
// previous pass, then appends the region or reports that there is no space.
// The result sits in an output register, so the next transfer is taken while it waits; a stalled
// result that is still waiting holds the next one in its last cycle.
module first_fit_region_allocator_core #(
    parameter int MAX_REGIONS      = 64,
    parameter int PAGE_NUMBER_BITS = 20
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic [PAGE_NUMBER_BITS:0] cfg_wdata,
    input  logic s_tvalid,
    output logic s_tready,
    // opcode, page_count, page_number, zero fill
    input  logic [((2 + 2*PAGE_NUMBER_BITS + 1 + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // status, first page of the region, run_pages, legitimate, zero fill
    output logic [((3 + 2*PAGE_NUMBER_BITS + 1 + 1 + 7) / 8) * 8 - 1:0] m_tdata
);
    import ffra_pkg::*;

    localparam int PB   = PAGE_NUMBER_BITS;
    localparam int CB   = PB + 1;
    localparam int XW   = PB + 3;
    localparam int AW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int NW   = $clog2(MAX_REGIONS + 1);
    localparam int DW   = CB + PB;
    localparam int MW   = ((3 + PB + CB + 1 + 7) / 8) * 8;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_REGIONS);

    state_t state_reg, state_next;

    logic [PB-1:0] base_reg;
    logic [CB-1:0] pool_reg;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [1:0]    op_reg, op_next;
    logic [CB-1:0] count_reg, count_next;
    logic [PB-1:0] page_reg, page_next;
    logic [XW-1:0] cand_reg, cand_next;
    logic          moved_reg, moved_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] eidx_reg, eidx_next;
    logic [NW-1:0] j_reg, j_next;

    logic [2:0]    rs_reg, rs_next;
    logic [PB-1:0] rf_reg, rf_next;
    logic [CB-1:0] rr_reg, rr_next;
    logic          rl_reg, rl_next;

    logic          mv_reg;
    logic [2:0]    os_reg;
    logic [PB-1:0] of_reg;
    logic [CB-1:0] or_reg;
    logic          ol_reg;

    logic          tbl_we, tbl_re;
    logic [AW-1:0] tbl_waddr, tbl_raddr;
    logic [DW-1:0] tbl_wdata, tbl_rdata;

    ffra_table #(.DEPTH(MAX_REGIONS), .AW(AW), .DW(DW)) u_table (
        .aclk (aclk),
        .we   (tbl_we),
        .waddr(tbl_waddr),
        .wdata(tbl_wdata),
        .re   (tbl_re),
        .raddr(tbl_raddr),
        .rdata(tbl_rdata)
    );

    logic [1:0]    in_op;
    logic [CB-1:0] in_count;
    logic [PB-1:0] in_page;
    assign in_op    = s_tdata[1:0];
    assign in_count = s_tdata[2+CB-1:2];
    assign in_page  = s_tdata[2+CB+PB-1:2+CB];

    logic [XW-1:0] e_start, e_end, limit, pool_top, fit_end;
    assign e_start  = XW'(tbl_rdata[PB-1:0]);
    assign e_end    = e_start + XW'(tbl_rdata[DW-1:PB]);
    assign pool_top = XW'(base_reg) + XW'(pool_reg);
    assign limit    = (pool_top > (XW'(1) << PB)) ? (XW'(1) << PB) : pool_top;
    assign fit_end  = cand_reg + XW'(count_reg);

    logic          accept, fin_go;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fin_go   = (state_reg == S_FIN) && (!mv_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        count_next = count_reg;
        page_next  = page_reg;
        cand_next  = cand_reg;
        moved_next = moved_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        eidx_next  = eidx_reg;
        j_next     = j_reg;
        rs_next    = rs_reg;
        rf_next    = rf_reg;
        rr_next    = rr_reg;
        rl_next    = rl_reg;
        tbl_we     = 1'b0;
        tbl_waddr  = cnt_reg[AW-1:0];
        tbl_wdata  = {count_reg, cand_reg[PB-1:0]};
        tbl_re     = 1'b0;
        tbl_raddr  = idx_reg[AW-1:0];
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next    = in_op;
                    count_next = in_count;
                    page_next  = in_page;
                    cand_next  = XW'(base_reg) + XW'(1);
                    moved_next = 1'b1;
                    idx_next   = '0;
                    rs_next    = ST_OK;
                    rf_next    = '0;
                    rr_next    = '0;
                    rl_next    = 1'b0;
                    case (in_op)
                        OP_ALLOC: begin
                            if (in_count == '0) begin
                                rs_next    = ST_NO_SPACE;
                                state_next = S_FIN;
                            end else if (cnt_reg >= MAX_N) begin
                                rs_next    = ST_FULL;
                                state_next = S_FIN;
                            end else begin
                                state_next = S_ACHK;
                            end
                        end
                        OP_RELEASE: begin
                            state_next = S_SCAN;
                        end
                        OP_CHECK: begin
                            if (in_page < base_reg || XW'(in_page) >= pool_top) begin
                                rs_next    = ST_OUTSIDE;
                                state_next = S_FIN;
                            end else if (in_page == base_reg) begin
                                rl_next    = 1'b1;
                                state_next = S_FIN;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ACHK: begin
                if (fit_end > limit) begin
                    rs_next    = ST_NO_SPACE;
                    state_next = S_FIN;
                end else if (!moved_reg) begin
                    tbl_we     = 1'b1;
                    cnt_next   = cnt_reg + NW'(1);
                    rf_next    = cand_reg[PB-1:0];
                    rr_next    = count_reg;
                    state_next = S_FIN;
                end else begin
                    moved_next = 1'b0;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (idx_reg < cnt_reg) begin
                    tbl_re    = 1'b1;
                    pend_next = 1'b1;
                    idx_next  = idx_reg + NW'(1);
                    eidx_next = idx_reg[AW-1:0];
                end
                if (pend_reg) begin
                    case (op_reg)
                        OP_ALLOC: begin
                            if (cand_reg < e_end && e_start < fit_end) begin
                                cand_next  = e_end;
                                moved_next = 1'b1;
                            end
                        end
                        OP_RELEASE: begin
                            if (tbl_rdata[PB-1:0] == page_reg) begin
                                rf_next    = tbl_rdata[PB-1:0];
                                rr_next    = tbl_rdata[DW-1:PB];
                                j_next     = NW'(eidx_reg);
                                pend_next  = 1'b0;
                                state_next = S_SHRD;
                            end
                        end
                        default: begin
                            if (XW'(page_reg) >= e_start && XW'(page_reg) < e_end) begin
                                rl_next    = 1'b1;
                                pend_next  = 1'b0;
                                state_next = S_FIN;
                            end
                        end
                    endcase
                end
                if (state_next == S_SCAN && !(idx_reg < cnt_reg)
                        && !(pend_reg && op_reg != OP_ALLOC && state_next != S_SCAN)) begin
                    if (!pend_reg || op_reg == OP_ALLOC || state_next == S_SCAN) begin
                        if (!pend_reg) begin
                            case (op_reg)
                                OP_ALLOC:   state_next = S_ACHK;
                                OP_RELEASE: begin
                                    rs_next    = ST_NOT_FOUND;
                                    state_next = S_FIN;
                                end
                                default: begin
                                    rs_next    = ST_NOT_ALLOC;
                                    state_next = S_FIN;
                                end
                            endcase
                        end
                    end
                end
            end
            S_SHRD: begin
                if (j_reg + NW'(1) < cnt_reg) begin
                    tbl_re     = 1'b1;
                    tbl_raddr  = AW'(j_reg + NW'(1));
                    state_next = S_SHWR;
                end else begin
                    cnt_next   = cnt_reg - NW'(1);
                    state_next = S_FIN;
                end
            end
            S_SHWR: begin
                tbl_we     = 1'b1;
                tbl_waddr  = j_reg[AW-1:0];
                tbl_wdata  = tbl_rdata;
                j_next     = j_reg + NW'(1);
                state_next = S_SHRD;
            end
            S_FIN: begin
                if (fin_go) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            mv_reg    <= 1'b0;
            base_reg  <= '0;
            pool_reg  <= CB'(1);
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            if (fin_go) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BASE_PAGE:  base_reg <= cfg_wdata[PB-1:0];
                    CFG_POOL_PAGES: pool_reg <= cfg_wdata;
                    default:        pool_reg <= pool_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        count_reg <= count_next;
        page_reg  <= page_next;
        cand_reg  <= cand_next;
        moved_reg <= moved_next;
        idx_reg   <= idx_next;
        eidx_reg  <= eidx_next;
        j_reg     <= j_next;
        rs_reg    <= rs_next;
        rf_reg    <= rf_next;
        rr_reg    <= rr_next;
        rl_reg    <= rl_next;
        if (fin_go) begin
            os_reg <= rs_reg;
            of_reg <= rf_reg;
            or_reg <= rr_reg;
            ol_reg <= rl_reg;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = MW'({ol_reg, or_reg, of_reg, os_reg});

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= MAX_N)
        else $error("region count above table depth");

    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_we |-> (state_reg == S_ACHK || state_reg == S_SHWR))
        else $error("table written outside append or shift");

    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHWR) |-> (j_reg + NW'(1) < cnt_reg))
        else $error("shift beyond occupied entries");

    a_release_shrink: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHRD && !(j_reg + NW'(1) < cnt_reg))
        |=> (cnt_reg == $past(cnt_reg) - NW'(1)))
        else $error("release did not remove one region");
endmodule

// ----- rtl/ffra_table.sv -----
`timescale 1ns / 1ps
module ffra_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 41
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- tb/sv/first_fit_region_allocator_core_test.sv -----
`timescale 1ns / 1ps
module first_fit_region_allocator_core_test;
    import ffra_pkg::*;

    localparam int MAXR = 64;
    localparam int PB = 20;
    localparam int SW = ((2 + 2*PB + 1 + 7) / 8) * 8;
    localparam int MW = ((3 + 2*PB + 1 + 1 + 7) / 8) * 8;
    localparam longint SPACE = 64'd1 << PB;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic          legitimate;
        logic [PB:0]   run_pages;
        logic [PB-1:0] start_page;
        logic [2:0]    status;
    } alloc_result_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic cfg_index = 0;
    logic [PB:0] cfg_wdata = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [MW-1:0] m_tdata;

    first_fit_region_allocator_core dut (.*);

    initial forever #4 aclk = ~aclk;

    longint base_r, pool_r;
    longint reg_start[MAXR];
    longint reg_len[MAXR];
    int reg_cnt;
    alloc_result_t expected_q[$];
    int errors = 0;
    int idle_cycles = 0;
    int burst_left = 0;

    function automatic alloc_result_t mk(int st, longint fp, longint rp, bit lg);
        alloc_result_t r;
        r.status = st[2:0];
        r.start_page = fp[PB-1:0];
        r.run_pages = rp[PB:0];
        r.legitimate = lg;
        return r;
    endfunction

    function automatic alloc_result_t predict_op(logic [1:0] op, longint cnt, longint pg);
        longint lim, cand, s, e;
        bit moved;
        if (op == OP_ALLOC) begin
            lim = base_r + pool_r;
            if (lim > SPACE) lim = SPACE;
            cand = base_r + 1;
            moved = 1;
            if (cnt == 0) return mk(ST_NO_SPACE, 0, 0, 0);
            if (reg_cnt >= MAXR) return mk(ST_FULL, 0, 0, 0);
            while (moved && cand + cnt <= lim) begin
                moved = 0;
                for (int i = 0; i < reg_cnt; i++) begin
                    s = reg_start[i];
                    e = s + reg_len[i];
                    if (cand < e && s < cand + cnt) begin
                        cand = e;
                        moved = 1;
                    end
                end
            end
            if (cand + cnt > lim) return mk(ST_NO_SPACE, 0, 0, 0);
            reg_start[reg_cnt] = cand;
            reg_len[reg_cnt] = cnt;
            reg_cnt++;
            return mk(ST_OK, cand, cnt, 0);
        end else if (op == OP_RELEASE) begin
            for (int i = 0; i < reg_cnt; i++) begin
                if (reg_start[i] == pg) begin
                    s = reg_start[i];
                    e = reg_len[i];
                    for (int j = i; j + 1 < reg_cnt; j++) begin
                        reg_start[j] = reg_start[j+1];
                        reg_len[j] = reg_len[j+1];
                    end
                    reg_cnt--;
                    return mk(ST_OK, s, e, 0);
                end
            end
            return mk(ST_NOT_FOUND, 0, 0, 0);
        end else begin
            if (pg < base_r || pg >= base_r + pool_r) return mk(ST_OUTSIDE, 0, 0, 0);
            if (pg == base_r) return mk(ST_OK, 0, 0, 1);
            for (int i = 0; i < reg_cnt; i++)
                if (pg >= reg_start[i] && pg < reg_start[i] + reg_len[i])
                    return mk(ST_OK, 0, 0, 1);
            return mk(ST_NOT_ALLOC, 0, 0, 0);
        end
    endfunction

    task automatic send_op(logic [1:0] op, longint cnt, longint pg);
        logic [PB:0] c;
        logic [PB-1:0] p;
        c = cnt[PB:0];
        p = pg[PB-1:0];
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 4)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1;
        s_tdata <= SW'({p, c, op});
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (op != 2'd3) expected_q.push_back(predict_op(op, cnt, pg));
        if (burst_left == 0) s_tvalid <= 0;
    endtask

    task automatic drain();
        if (burst_left != 0) s_tvalid <= 0;
        burst_left = 0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_cfg(logic idx, longint v);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= v[PB:0];
        @(posedge aclk);
        if (idx == CFG_BASE_PAGE) base_r = v & (SPACE - 1);
        else pool_r = v & (2*SPACE - 1);
    endtask

    task automatic set_pool(longint b, longint n);
        drain();
        write_cfg(CFG_BASE_PAGE, b);
        write_cfg(CFG_POOL_PAGES, n);
        cfg_we <= 0;
    endtask

    always @(posedge aclk) begin
        alloc_result_t got, exp;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[3+2*PB+1:0];
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result %h", $time, got);
                end else begin
                    exp = expected_q.pop_front();
                    if (got.status !== exp.status)
                        $display("%0t status exp %0d got %0d", $time, exp.status, got.status);
                    if (got.start_page !== exp.start_page)
                        $display("%0t start_page exp %h got %h", $time,
                                 exp.start_page, got.start_page);
                    if (got.run_pages !== exp.run_pages)
                        $display("%0t run_pages exp %h got %h", $time,
                                 exp.run_pages, got.run_pages);
                    if (got.legitimate !== exp.legitimate)
                        $display("%0t legitimate exp %0d got %0d", $time,
                                 exp.legitimate, got.legitimate);
                    if (got !== exp) errors++;
                end
            end
            case ($urandom_range(0, 3))
                0: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($time / 2000) % 3 != 0 || $urandom_range(0, 1);
            endcase
        end
    end

    task automatic test_directed();
        set_pool(0, 1);
        send_op(OP_ALLOC, 1, 0);
        send_op(OP_CHECK, 0, 0);
        send_op(OP_CHECK, 0, 1);
        set_pool(0, 0);
        send_op(OP_ALLOC, 1, 0);
        send_op(OP_CHECK, 0, 0);
        set_pool(100, 20);
        send_op(OP_ALLOC, 0, 0);
        send_op(OP_ALLOC, 5, 0);
        send_op(OP_ALLOC, 3, 0);
        send_op(OP_ALLOC, 20, 0);
        send_op(OP_CHECK, 0, 99);
        send_op(OP_CHECK, 0, 120);
        send_op(OP_CHECK, 0, 100);
        send_op(OP_CHECK, 0, 103);
        send_op(OP_CHECK, 0, 115);
        send_op(OP_RELEASE, 0, 101);
        send_op(OP_RELEASE, 0, 101);
        send_op(2'd3, 21'h1FFFFF, 20'hFFFFF);
        send_op(OP_ALLOC, 2, 0);
        set_pool(SPACE - 1, 2*SPACE - 1);
        send_op(OP_ALLOC, 1, 0);
        send_op(OP_CHECK, 0, SPACE - 1);
        send_op(OP_ALLOC, 2*SPACE - 1, 0);
        set_pool(1, 2*SPACE - 1);
        send_op(OP_ALLOC, SPACE - 1, 0);
        send_op(OP_RELEASE, 0, 2);
    endtask

    task automatic test_full_table();
        set_pool(10, 200);
        for (int i = 0; i < MAXR + 2; i++) send_op(OP_ALLOC, 1, 0);
        for (int i = 0; i < MAXR; i += 2) send_op(OP_RELEASE, 0, 11 + i);
        send_op(OP_ALLOC, 1, 0);
        send_op(OP_ALLOC, 2, 0);
    endtask

    task automatic random_phase(longint b, longint n, int items);
        longint pg, c;
        set_pool(b, n);
        for (int k = 0; k < items; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    c = (n > 40) ? $urandom_range(1, 16) : $urandom_range(0, 5);
                    if ($urandom_range(0, 19) == 0) c = {$urandom, $urandom} & (2*SPACE - 1);
                    send_op(OP_ALLOC, c, 0);
                end
                4, 5: begin
                    if (reg_cnt > 0 && $urandom_range(0, 3) != 0)
                        pg = reg_start[$urandom_range(0, reg_cnt - 1)];
                    else pg = $urandom & (SPACE - 1);
                    send_op(OP_RELEASE, $urandom & (2*SPACE - 1), pg);
                end
                6, 7, 8: begin
                    if ($urandom_range(0, 4) == 0) pg = $urandom & (SPACE - 1);
                    else pg = (b + $urandom_range(0, 300) - 5) & (SPACE - 1);
                    send_op(OP_CHECK, $urandom & (2*SPACE - 1), pg);
                end
                default: send_op(2'd3, $urandom & (2*SPACE - 1), $urandom & (SPACE - 1));
            endcase
        end
    endtask

    initial begin
        base_r = 0;
        pool_r = 1;
        reg_cnt = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_directed();
        test_full_table();
        random_phase(SPACE - 200, 2*SPACE - 1, 150);
        random_phase($urandom & 16'hFFFF, 60, 150);
        random_phase($urandom & (SPACE - 1), 300, 150);
        random_phase(5, 12, 120);
        drain();
        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
